// ----- hw/rtl/rvm_pkg.sv -----
`timescale 1ns / 1ps

package rvm_pkg;

    localparam int FRAC_BITS    = 11;
    localparam int SAMPLE_DEPTH = 65536;
    localparam int ADDR_W       = $clog2(SAMPLE_DEPTH);
    localparam int PHASE_W      = ADDR_W + FRAC_BITS;

    localparam int SAMPLE_W     = 8;
    localparam int ADDR_IN_W    = 16;
    localparam int PHASE_IN_W   = 27;
    localparam int STEP_W       = 27;
    localparam int VOL_W        = 10;
    localparam int ACC_W        = 32;
    localparam int WIDEN_SHIFT  = 8;
    localparam int PROD_W       = VOL_W + 1 + SAMPLE_W;

    localparam int OP_W         = 2;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 27;

    localparam int IN_BITS      = ADDR_IN_W + SAMPLE_W + PHASE_IN_W + 2 * ACC_W;
    localparam int IN_DATA_W    = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS     = 2 * ACC_W + PHASE_IN_W;
    localparam int OUT_DATA_W   = ((OUT_BITS + 7) / 8) * 8;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE     = 2'd0,
        OP_SET_PHASE = 2'd1,
        OP_MIX       = 2'd2
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PHASE_STEP   = 2'd0,
        CFG_LEFT_VOLUME  = 2'd1,
        CFG_RIGHT_VOLUME = 2'd2,
        CFG_STEREO_MODE  = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [VOL_W-1:0] left_volume;
        logic [VOL_W-1:0] right_volume;
        logic             stereo_mode;
    } mix_cfg_t;

endpackage

// ----- hw/rtl/rvm_ram.sv -----
`timescale 1ns / 1ps

module rvm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- hw/rtl/rvm_mix.sv -----
`timescale 1ns / 1ps

module rvm_mix (
    input  logic signed [rvm_pkg::SAMPLE_W-1:0] sample,
    input  rvm_pkg::mix_cfg_t                   cfg,
    input  logic        [rvm_pkg::ACC_W-1:0]    left_accum,
    input  logic        [rvm_pkg::ACC_W-1:0]    right_accum,
    output logic        [rvm_pkg::ACC_W-1:0]    left_mix,
    output logic        [rvm_pkg::ACC_W-1:0]    right_mix
);

    import rvm_pkg::*;

    logic signed [PROD_W-1:0] left_prod;
    logic signed [PROD_W-1:0] right_prod;
    logic        [ACC_W-1:0]  left_term;
    logic        [ACC_W-1:0]  right_term;

    always_comb
    begin
        left_prod  = $signed({1'b0, cfg.left_volume}) * sample;
        right_prod = $signed({1'b0, cfg.right_volume}) * sample;
        left_term  = ACC_W'(left_prod) << WIDEN_SHIFT;
        right_term = ACC_W'(right_prod) << WIDEN_SHIFT;
        left_mix   = left_accum + left_term;
        if (cfg.stereo_mode)
        begin
            right_mix = right_accum + right_term;
        end
        else
        begin
            right_mix = right_accum;
        end
    end

endmodule

// ----- hw/rtl/resampling_voice_mixer.sv -----
`timescale 1ns / 1ps

// Nearest-neighbor resampling voice mixer.
// s_axis carries requests: tuser is the op (write sample, set phase, mix one
// frame), tdata the payload. Write requests store one 8-bit sample, set-phase
// requests load the play position; neither returns anything. Each mix request
// returns one result on m_axis: the left accumulator with the scaled sample
// added, the right one likewise in stereo mode, and the play position after the step.
// cfg_valid/cfg_ready/cfg_index/cfg_data write the step, volumes and stereo
// mode; cfg_ready is always high. Write registers only while idle.
// A mix result passes the sample memory read, which registers at the edge
// that accepts its request, and then the result register, which feeds
// m_axis. One request per cycle in any op mix while no held result blocks
// the read stage.
// Stall: with m_axis_tready low the result register holds; one more mix
// request fits into the read stage, then s_axis_tready drops until the
// result is taken.
// Reset: play position 0, step 2048, volumes 0, stereo on, no result
// pending. Sample memory contents are undefined until written.
module resampling_voice_mixer (
    input  logic                               clk,
    input  logic                               rst_n,
    // s_axis_tdata, low bit up: sample_address[15:0], sample_value[7:0],
    // phase_value[26:0], left_accum[31:0], right_accum[31:0], zero pad
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [rvm_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    input  logic [rvm_pkg::OP_W-1:0]           s_axis_tuser,   // op[1:0]
    // m_axis_tdata, low bit up: left_mix[31:0], right_mix[31:0],
    // phase_out[26:0], zero pad
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [rvm_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [rvm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rvm_pkg::CFG_DATA_W-1:0]     cfg_data
);

    import rvm_pkg::*;

    localparam int SV_LO = ADDR_IN_W;
    localparam int PV_LO = SV_LO + SAMPLE_W;
    localparam int LA_LO = PV_LO + PHASE_IN_W;
    localparam int RA_LO = LA_LO + ACC_W;

    logic [ADDR_IN_W-1:0]   in_address;
    logic [SAMPLE_W-1:0]    in_sample;
    logic [PHASE_IN_W-1:0]  in_phase;
    logic [ACC_W-1:0]       in_left;
    logic [ACC_W-1:0]       in_right;
    op_t                    in_op;
    logic                   in_accept;
    logic                   wr_en;
    logic                   mix_en;

    logic [STEP_W-1:0]      phase_step_reg;
    logic [VOL_W-1:0]       left_volume_reg;
    logic [VOL_W-1:0]       right_volume_reg;
    logic                   stereo_mode_reg;
    logic [PHASE_W-1:0]     phase_reg;
    logic [PHASE_W-1:0]     phase_next;

    logic                   s1_valid_reg;
    logic [ACC_W-1:0]       s1_left_reg;
    logic [ACC_W-1:0]       s1_right_reg;
    logic [PHASE_IN_W-1:0]  s1_phase_reg;
    logic                   s1_free;
    logic                   out_free;

    logic                   m_valid_reg;
    logic [OUT_DATA_W-1:0]  m_data_reg;

    logic [SAMPLE_W-1:0]    rd_sample;
    mix_cfg_t               mix_cfg;
    logic [ACC_W-1:0]       left_mix;
    logic [ACC_W-1:0]       right_mix;

    assign in_address = s_axis_tdata[SV_LO-1:0];
    assign in_sample  = s_axis_tdata[PV_LO-1:SV_LO];
    assign in_phase   = s_axis_tdata[LA_LO-1:PV_LO];
    assign in_left    = s_axis_tdata[RA_LO-1:LA_LO];
    assign in_right   = s_axis_tdata[RA_LO+ACC_W-1:RA_LO];
    assign in_op      = op_t'(s_axis_tuser);

    assign out_free      = !m_valid_reg || m_axis_tready;
    assign s1_free       = !s1_valid_reg || out_free;
    assign s_axis_tready = s1_free;
    assign in_accept     = s_axis_tvalid && s1_free;
    assign wr_en         = in_accept && (in_op == OP_WRITE);
    assign mix_en        = in_accept && (in_op == OP_MIX);
    assign cfg_ready     = 1'b1;

    always_comb
    begin
        phase_next = phase_reg;
        if (in_accept)
        begin
            case (in_op)
                OP_SET_PHASE: phase_next = PHASE_W'(in_phase);
                OP_MIX:       phase_next = phase_reg + PHASE_W'($signed(phase_step_reg));
                default:      phase_next = phase_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_step_reg   <= STEP_W'(2048);
            left_volume_reg  <= '0;
            right_volume_reg <= '0;
            stereo_mode_reg  <= 1'b1;
        end
        else if (cfg_valid)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_PHASE_STEP:   phase_step_reg   <= cfg_data[STEP_W-1:0];
                CFG_LEFT_VOLUME:  left_volume_reg  <= cfg_data[VOL_W-1:0];
                CFG_RIGHT_VOLUME: right_volume_reg <= cfg_data[VOL_W-1:0];
                CFG_STEREO_MODE:  stereo_mode_reg  <= cfg_data[0];
                default:          phase_step_reg   <= phase_step_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= '0;
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            if (s1_free)
            begin
                s1_valid_reg <= mix_en;
            end
            if (out_free)
            begin
                m_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mix_en)
        begin
            s1_left_reg  <= in_left;
            s1_right_reg <= in_right;
            s1_phase_reg <= PHASE_IN_W'(phase_next);
        end
        if (out_free && s1_valid_reg)
        begin
            m_data_reg <= OUT_DATA_W'({s1_phase_reg, right_mix, left_mix});
        end
    end

    rvm_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (SAMPLE_DEPTH)
    ) u_sample_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (ADDR_W'(in_address)),
        .wr_data (in_sample),
        .rd_en   (mix_en),
        .rd_addr (phase_reg[PHASE_W-1:FRAC_BITS]),
        .rd_data (rd_sample)
    );

    assign mix_cfg.left_volume  = left_volume_reg;
    assign mix_cfg.right_volume = right_volume_reg;
    assign mix_cfg.stereo_mode  = stereo_mode_reg;

    rvm_mix u_mix (
        .sample      ($signed(rd_sample)),
        .cfg         (mix_cfg),
        .left_accum  (s1_left_reg),
        .right_accum (s1_right_reg),
        .left_mix    (left_mix),
        .right_mix   (right_mix)
    );

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule

// ----- verif/tb_resampling_voice_mixer.sv -----
`timescale 1ns / 1ps

module tb_resampling_voice_mixer;
    import rvm_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 4;
    localparam int STALL_LIMIT   = 5000;
    localparam int REPORT_LIMIT  = 10;

    typedef struct packed {
        logic [IN_DATA_W-IN_BITS-1:0] pad;
        logic [ACC_W-1:0]             right_accum;
        logic [ACC_W-1:0]             left_accum;
        logic [PHASE_IN_W-1:0]        phase_value;
        logic [SAMPLE_W-1:0]          sample_value;
        logic [ADDR_IN_W-1:0]         sample_address;
    } request_t;

    typedef struct packed {
        logic [OUT_DATA_W-OUT_BITS-1:0] pad;
        logic [PHASE_IN_W-1:0]          phase_out;
        logic [ACC_W-1:0]               right_mix;
        logic [ACC_W-1:0]               left_mix;
    } frame_t;

    logic                   clk;
    logic                   rst_n         = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_DATA_W-1:0]   s_axis_tdata  = '0;
    logic [OP_W-1:0]        s_axis_tuser  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;
    logic                   cfg_valid     = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index     = '0;
    logic [CFG_DATA_W-1:0]  cfg_data      = '0;

    // voice state as the block should hold it
    logic [SAMPLE_W-1:0]    voice_mem [SAMPLE_DEPTH];
    bit                     voice_written [SAMPLE_DEPTH];
    logic [PHASE_W-1:0]     voice_phase   = '0;
    logic [STEP_W-1:0]      step_reg      = STEP_W'(2048);
    logic [VOL_W-1:0]       left_vol_reg  = '0;
    logic [VOL_W-1:0]       right_vol_reg = '0;
    logic                   stereo_reg    = 1'b1;

    frame_t                 pending_frames [$];
    frame_t                 seen_frame;
    frame_t                 due_frame;

    int                     mismatches     = 0;
    int                     quiet_cycles   = 0;
    int                     src_idle_pct   = 0;
    int                     sink_stall_pct = 0;
    int                     hold_cycles    = 0;

    resampling_voice_mixer dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic logic [ACC_W-1:0] scaled_sum(logic [ACC_W-1:0] acc,
                                                    logic [VOL_W-1:0] vol,
                                                    logic [SAMPLE_W-1:0] smp);
        longint prod;
        prod = longint'($signed(smp)) * 256 * longint'(vol);
        return acc + prod[ACC_W-1:0];
    endfunction

    function automatic void advance_voice(logic [OP_W-1:0] op, request_t req);
        frame_t             f;
        logic [ADDR_W-1:0]  pos;
        case (op)
            OP_WRITE:
            begin
                voice_mem[req.sample_address]     = req.sample_value;
                voice_written[req.sample_address] = 1'b1;
            end
            OP_SET_PHASE:
                voice_phase = req.phase_value;
            OP_MIX:
            begin
                pos         = voice_phase[PHASE_W-1 -: ADDR_W];
                f           = '0;
                f.left_mix  = scaled_sum(req.left_accum, left_vol_reg, voice_mem[pos]);
                f.right_mix = stereo_reg ?
                              scaled_sum(req.right_accum, right_vol_reg, voice_mem[pos]) :
                              req.right_accum;
                voice_phase = voice_phase + step_reg;
                f.phase_out = voice_phase;
                pending_frames.push_back(f);
            end
            default: ;
        endcase
    endfunction

    function automatic logic [ACC_W-1:0] rand_accum();
        case ($urandom_range(9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic request_t rand_request();
        request_t r;
        r.pad            = '0;
        r.right_accum    = rand_accum();
        r.left_accum     = rand_accum();
        r.phase_value    = PHASE_IN_W'($urandom);
        r.sample_value   = SAMPLE_W'($urandom);
        r.sample_address = ADDR_IN_W'($urandom);
        return r;
    endfunction

    function automatic logic [VOL_W-1:0] pick_volume();
        case ($urandom_range(4))
            0: return '0;
            1: return VOL_W'(512);
            2: return '1;
            default: return VOL_W'($urandom_range(1023));
        endcase
    endfunction

    task automatic send_request(logic [OP_W-1:0] op, request_t req);
        while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= req;
        do @(posedge clk); while (!s_axis_tready);
        advance_voice(op, req);
    endtask

    task automatic write_sample(logic [ADDR_IN_W-1:0] addr, logic [SAMPLE_W-1:0] val);
        request_t r;
        r                = rand_request();
        r.sample_address = addr;
        r.sample_value   = val;
        send_request(OP_WRITE, r);
    endtask

    task automatic set_phase(logic [PHASE_IN_W-1:0] ph);
        request_t r;
        r             = rand_request();
        r.phase_value = ph;
        send_request(OP_SET_PHASE, r);
    endtask

    task automatic mix_frame(logic [ACC_W-1:0] left_acc, logic [ACC_W-1:0] right_acc);
        request_t           r;
        logic [ADDR_W-1:0]  pos;
        pos = voice_phase[PHASE_W-1 -: ADDR_W];
        // load the sample under the play position first if it was never written
        if (!voice_written[pos])
            write_sample(pos, SAMPLE_W'($urandom));
        r             = rand_request();
        r.left_accum  = left_acc;
        r.right_accum = right_acc;
        send_request(OP_MIX, r);
    endtask

    task automatic settle(int tail);
        s_axis_tvalid <= 1'b0;
        while (pending_frames.size() != 0)
            @(posedge clk);
        repeat (tail) @(posedge clk);
    endtask

    task automatic cfg_put(cfg_index_t idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_PHASE_STEP:   step_reg      = data[STEP_W-1:0];
            CFG_LEFT_VOLUME:  left_vol_reg  = data[VOL_W-1:0];
            CFG_RIGHT_VOLUME: right_vol_reg = data[VOL_W-1:0];
            CFG_STEREO_MODE:  stereo_reg    = data[0];
            default: ;
        endcase
    endtask

    task automatic configure(logic [STEP_W-1:0] step, logic [VOL_W-1:0] left_vol,
                             logic [VOL_W-1:0] right_vol, logic stereo);
        logic [CFG_DATA_W-1:0] junk;
        settle(SETTLE_CYCLES);
        cfg_put(CFG_PHASE_STEP, step);
        // fill unused upper bits with noise
        junk = CFG_DATA_W'($urandom);
        cfg_put(CFG_LEFT_VOLUME, {junk[CFG_DATA_W-1:VOL_W], left_vol});
        junk = CFG_DATA_W'($urandom);
        cfg_put(CFG_RIGHT_VOLUME, {junk[CFG_DATA_W-1:VOL_W], right_vol});
        junk = CFG_DATA_W'($urandom);
        cfg_put(CFG_STEREO_MODE, {junk[CFG_DATA_W-1:1], stereo});
        cfg_valid <= 1'b0;
    endtask

    task automatic random_config();
        logic [STEP_W-1:0] step;
        case ($urandom_range(5))
            0: step = STEP_W'($urandom_range(4096));
            1: step = ~STEP_W'($urandom_range(4095));
            2: step = STEP_W'($urandom);
            3: step = 27'h3FF_FFFF;
            4: step = 27'h400_0000;
            default: step = STEP_W'(2048);
        endcase
        configure(step, pick_volume(), pick_volume(), 1'($urandom_range(1)));
    endtask

    task automatic test_reset_defaults();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        write_sample(16'h0000, 8'h80);
        write_sample(16'h0001, 8'h7F);
        write_sample(16'hFFFF, 8'h01);
        write_sample(16'h0002, 8'h00);
        mix_frame(32'h7FFF_FFFF, 32'h8000_0000);
        mix_frame(32'h0000_0000, 32'hFFFF_FFFF);
        send_request(OP_UNUSED, rand_request());
        mix_frame(rand_accum(), rand_accum());
        configure(STEP_W'(2048), VOL_W'(512), VOL_W'(512), 1'b1);
        set_phase('0);
        mix_frame(32'h7FFF_FFFF, 32'h8000_0000);
        mix_frame(32'h8000_0000, 32'h7FFF_FFFF);
    endtask

    task automatic test_register_extremes();
        configure(27'h400_0000, 10'h3FF, 10'h200, 1'b0);
        set_phase('0);
        mix_frame(32'h7FFF_FFFF, 32'h8000_0000);
        mix_frame(rand_accum(), rand_accum());
        set_phase(27'h7FF_FFFF);
        mix_frame(32'h8000_0000, 32'h7FFF_FFFF);
        configure(27'h3FF_FFFF, 10'h000, 10'h3FF, 1'b1);
        set_phase(27'h7FF_F800);
        mix_frame(rand_accum(), rand_accum());
        mix_frame(32'h7FFF_FFFF, 32'h8000_0000);
        // step of minus one wraps below zero
        configure(27'h7FF_FFFF, 10'h200, 10'h200, 1'b1);
        set_phase('0);
        mix_frame(32'h0000_0000, 32'h0000_0000);
        mix_frame(rand_accum(), rand_accum());
        send_request(OP_UNUSED, rand_request());
    endtask

    task automatic test_random_traffic(int count, int src_pct, int sink_pct);
        int kind;
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        for (int i = 0; i < count; i++)
        begin
            if (i % 50 == 0)
                random_config();
            kind = $urandom_range(99);
            if (kind < 5)
                send_request(OP_UNUSED, rand_request());
            else if (kind < 12)
                write_sample(ADDR_IN_W'($urandom), SAMPLE_W'($urandom));
            else if (kind < 20)
                write_sample(ADDR_IN_W'(voice_phase[PHASE_W-1 -: ADDR_W] + $urandom_range(7)),
                             SAMPLE_W'($urandom));
            else if (kind < 27)
                set_phase(PHASE_IN_W'($urandom));
            else
                mix_frame(rand_accum(), rand_accum());
        end
    endtask

    task automatic test_output_holdoff();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        hold_cycles    = 300;
        repeat (30) mix_frame(rand_accum(), rand_accum());
        settle(SETTLE_CYCLES);
    endtask

    task automatic test_sender_pause();
        src_idle_pct   = 22;
        sink_stall_pct = 22;
        repeat (12) mix_frame(rand_accum(), rand_accum());
        settle(0);
        repeat (12) mix_frame(rand_accum(), rand_accum());
    endtask

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                hold_cycles = hold_cycles - 1;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= (sink_stall_pct == 0) || ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            seen_frame = m_axis_tdata;
            if (pending_frames.size() == 0)
            begin
                if (mismatches < REPORT_LIMIT)
                    $display("unexpected mix result: left %h right %h phase %h",
                             seen_frame.left_mix, seen_frame.right_mix, seen_frame.phase_out);
                mismatches++;
            end
            else
            begin
                due_frame = pending_frames.pop_front();
                if (seen_frame.left_mix !== due_frame.left_mix ||
                    seen_frame.right_mix !== due_frame.right_mix ||
                    seen_frame.phase_out !== due_frame.phase_out)
                begin
                    if (mismatches < REPORT_LIMIT)
                        $display("mismatch: exp L %h R %h P %h, got L %h R %h P %h",
                                 due_frame.left_mix, due_frame.right_mix, due_frame.phase_out,
                                 seen_frame.left_mix, seen_frame.right_mix, seen_frame.phase_out);
                    mismatches++;
                end
            end
        end
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        test_reset_defaults();
        test_register_extremes();
        test_random_traffic(110, 0, 0);
        test_random_traffic(110, 76, 0);
        test_random_traffic(110, 0, 76);
        test_random_traffic(110, 22, 22);
        test_output_holdoff();
        test_sender_pause();
        settle(8);
        if (mismatches == 0 && pending_frames.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
